>>> hw/rtl/ffha_pkg.sv
package ffha_pkg;

	localparam int DEF_HEAP_BYTES   = 65536;
	localparam int DEF_HEADER_BYTES = 32;
	localparam int DEF_MAX_BLOCKS   = 64;

	localparam int REQ_W = 17;
	localparam int DAT_W = 16;
	localparam int RES_W = 16;
	localparam int GRW_W = 17;
	localparam int PA_W  = 3;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic REG_MIN_GROW = 1'b0;
	localparam logic [GRW_W-1:0] MIN_GROW_RST = 17'd1024;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_ZERO    = 2'd1,
		ST_FULL    = 2'd2,
		ST_BADFREE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CALC,
		S_WALK,
		S_HOLD
	} fsm_t;

	// request broadcast to every cell
	typedef struct packed {
		logic             cmd;
		logic [REQ_W-1:0] req;
		logic [DAT_W-1:0] dat;
	} bc_t;

	// chain edits raised by the cell that holds the live token
	typedef struct packed {
		logic grow;
		logic split;
		logic nmerge;
		logic pmerge;
	} act_t;

	// token handed from cell to cell; carries the answer once decided
	typedef struct packed {
		logic             tok;
		logic             done;
		status_t          st;
		logic [RES_W-1:0] res;
	} tok_t;

endpackage

>>> hw/rtl/ffha_grow.sv
module ffha_grow #(
	parameter int NW = 18,
	parameter int CW = 19
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [NW-1:0]                need,
	input  logic [ffha_pkg::GRW_W-1:0]   gran,
	output logic                         done,
	output logic [CW-1:0]                calc
);

	localparam int CNT_W = $clog2(NW + 1);

	logic                       run_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [NW-1:0]              sh_q;
	logic [NW-1:0]              need_q;
	logic [ffha_pkg::GRW_W-1:0] g_q;
	logic [ffha_pkg::GRW_W-1:0] rem_q;
	logic [ffha_pkg::GRW_W:0]   trial;
	logic [ffha_pkg::GRW_W:0]   diff;

	assign trial = {rem_q, sh_q[NW-1]};
	assign diff  = trial - {1'b0, g_q};
	assign done  = run_q && (cnt_q == '0);

	// round up to a granule multiple: need - rem + (rem ? g : 0)
	assign calc = CW'(need_q) - CW'(rem_q) + ((rem_q != '0) ? CW'(g_q) : CW'(0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= CNT_W'(NW);
		end else if (run_q) begin
			if (cnt_q == '0)
				run_q <= 1'b0;
			else
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// restoring remainder, one bit a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			sh_q   <= need;
			need_q <= need;
			g_q    <= gran;
			rem_q  <= '0;
		end else if (run_q && (cnt_q != '0)) begin
			sh_q <= {sh_q[NW-2:0], 1'b0};
			if (trial >= {1'b0, g_q})
				rem_q <= diff[ffha_pkg::GRW_W-1:0];
			else
				rem_q <= trial[ffha_pkg::GRW_W-1:0];
		end
	end

endmodule

>>> hw/rtl/ffha_cell.sv
module ffha_cell #(
	parameter int HEAP = 65536,
	parameter int HDR  = 32,
	parameter int AW   = 17,
	parameter int NW   = 18,
	parameter int CW   = 19
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ffha_pkg::bc_t       bc,
	input  logic [NW-1:0]       need,
	input  logic [CW-1:0]       calc,
	input  logic [AW-1:0]       heap_top,
	input  logic                table_full,
	input  logic                launch,
	input  ffha_pkg::act_t      act,
	input  logic                dn_v,
	input  logic [AW-1:0]       dn_size,
	input  logic [AW-1:0]       dn_cap,
	input  logic                dn_tok,
	input  logic                up1_v,
	input  logic [AW-1:0]       up1_size,
	input  logic [AW-1:0]       up1_cap,
	input  logic                up1_tok,
	input  logic                up2_v,
	input  logic [AW-1:0]       up2_size,
	input  logic [AW-1:0]       up2_cap,
	input  ffha_pkg::tok_t      tin,
	input  logic [AW-1:0]       tin_off,
	output logic                v,
	output logic [AW-1:0]       size,
	output logic [AW-1:0]       cap,
	output logic                tok,
	output ffha_pkg::tok_t      tout,
	output logic [AW-1:0]       tout_off,
	output ffha_pkg::act_t      act_req
);

	localparam int XW = ((AW > CW) ? AW : CW) + 2;

	logic               v_q;
	logic [AW-1:0]      size_q;
	logic [AW-1:0]      cap_q;
	ffha_pkg::tok_t     tk_q;
	logic [AW-1:0]      off_q;
	logic               pass_q;

	logic               nv;
	logic [AW-1:0]      ns;
	logic [AW-1:0]      nc;

	logic               active;
	logic [XW-1:0]      hdr_x, off_x, size_x, cap_x, req_x, need_x, data_x;
	logic [XW-1:0]      res_split, res_grow, off_next, top_sum;
	logic               fit, slack_ok, hit, nm, pm, grow_ok;

	assign v    = v_q;
	assign size = size_q;
	assign cap  = cap_q;
	assign tok  = tk_q.tok;

	assign active = tk_q.tok && !tk_q.done;

	assign hdr_x  = XW'(HDR);
	assign off_x  = XW'(off_q);
	assign size_x = XW'(size_q);
	assign cap_x  = XW'(cap_q);
	assign req_x  = XW'(bc.req);
	assign need_x = XW'(need);
	assign data_x = off_x + hdr_x;

	assign res_split = data_x + size_x + hdr_x;
	assign res_grow  = XW'(heap_top) + hdr_x;
	assign off_next  = data_x + cap_x;
	assign top_sum   = XW'(heap_top) + XW'(calc);

	assign fit      = v_q && (size_q == '0) && (cap_x >= req_x);
	assign slack_ok = (cap_x >= size_x) && ((cap_x - size_x) >= need_x);
	assign hit      = v_q && (data_x == XW'(bc.dat));
	assign nm       = up1_v && (up1_size == '0);
	assign pm       = dn_v && (dn_size == '0);
	assign grow_ok  = top_sum <= XW'(HEAP);

	// decision made by the cell holding the live token
	always_comb begin
		tout     = tk_q;
		tout_off = off_q;
		act_req  = '0;
		if (active) begin
			if (bc.cmd == ffha_pkg::CMD_ALLOC) begin
				if (v_q) begin
					if (fit) begin
						tout.done = 1'b1;
						tout.st   = ffha_pkg::ST_OK;
						tout.res  = data_x[ffha_pkg::RES_W-1:0];
					end else if (slack_ok) begin
						tout.done = 1'b1;
						if (table_full) begin
							tout.st = ffha_pkg::ST_FULL;
						end else begin
							tout.st       = ffha_pkg::ST_OK;
							tout.res      = res_split[ffha_pkg::RES_W-1:0];
							act_req.split = 1'b1;
						end
					end else begin
						tout_off = off_next[AW-1:0];
					end
				end else begin
					// end of list: append at the heap top
					tout.done = 1'b1;
					if (grow_ok) begin
						tout.st      = ffha_pkg::ST_OK;
						tout.res     = res_grow[ffha_pkg::RES_W-1:0];
						act_req.grow = 1'b1;
					end else begin
						tout.st = ffha_pkg::ST_FULL;
					end
				end
			end else begin
				if (v_q) begin
					if (hit) begin
						tout.done = 1'b1;
						if (size_q == '0) begin
							tout.st = ffha_pkg::ST_BADFREE;
						end else begin
							tout.st        = ffha_pkg::ST_OK;
							act_req.nmerge = nm;
							act_req.pmerge = pm;
						end
					end else begin
						tout_off = off_next[AW-1:0];
					end
				end else begin
					tout.done = 1'b1;
					tout.st   = ffha_pkg::ST_BADFREE;
				end
			end
		end
	end

	always_comb begin
		nv = v_q;
		ns = size_q;
		nc = cap_q;
		if (active) begin
			if (act_req.split) begin
				nc = size_q;
			end else if (act_req.grow) begin
				nv = 1'b1;
				ns = AW'(bc.req);
				nc = AW'(XW'(calc) - hdr_x);
			end else if (bc.cmd == ffha_pkg::CMD_ALLOC && fit) begin
				ns = AW'(bc.req);
			end else if (bc.cmd == ffha_pkg::CMD_FREE && hit && size_q != '0) begin
				if (pm) begin
					nv = nm ? up2_v : up1_v;
					ns = nm ? up2_size : up1_size;
					nc = nm ? up2_cap : up1_cap;
				end else begin
					ns = '0;
					if (nm)
						nc = AW'(cap_x + hdr_x + XW'(up1_cap));
				end
			end
		end else if (up1_tok && act.pmerge) begin
			// previous neighbor absorbs the freed block (and its free successor)
			nc = AW'(cap_x + hdr_x + XW'(up1_cap) +
				(act.nmerge ? hdr_x + XW'(up2_cap) : XW'(0)));
		end else if (!pass_q && !tk_q.tok) begin
			if (act.split) begin
				if (dn_tok) begin
					nv = 1'b1;
					ns = AW'(bc.req);
					nc = AW'(XW'(dn_cap) - hdr_x - XW'(dn_size));
				end else begin
					nv = dn_v;
					ns = dn_size;
					nc = dn_cap;
				end
			end else if (act.nmerge || act.pmerge) begin
				nv = (act.nmerge && act.pmerge) ? up2_v : up1_v;
				ns = (act.nmerge && act.pmerge) ? up2_size : up1_size;
				nc = (act.nmerge && act.pmerge) ? up2_cap : up1_cap;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q    <= 1'b0;
			tk_q   <= '0;
			pass_q <= 1'b0;
		end else begin
			v_q  <= nv;
			tk_q <= tin;
			if (launch)
				pass_q <= 1'b0;
			else if (tk_q.tok)
				pass_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		size_q <= ns;
		cap_q  <= nc;
		off_q  <= tin_off;
	end

endmodule

>>> hw/rtl/first_fit_heap_allocator_top.sv
// First-fit heap allocator. Block records live in a chain of MAX_BLOCKS cells kept in
// address order, valid cells packed at the bottom; a block's offset is the running sum of
// header plus capacity below it. One item is handled at a time. An item first has request plus
// header rounded up to the grow granule in a bit-serial remainder unit, then a token crosses
// the chain one cell per cycle, so the walk always spans all MAX_BLOCKS cells whatever the fill;
// splits and merges shift the cells above the token by one or two places in the cycle the
// token decides. No clearing pass after reset.
module first_fit_heap_allocator_top #(
	parameter int HEAP_BYTES   = ffha_pkg::DEF_HEAP_BYTES,
	parameter int HEADER_BYTES = ffha_pkg::DEF_HEADER_BYTES,
	parameter int MAX_BLOCKS   = ffha_pkg::DEF_MAX_BLOCKS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         command,
	input  logic [ffha_pkg::REQ_W-1:0]   request_size,
	input  logic [ffha_pkg::DAT_W-1:0]   data_offset,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [ffha_pkg::RES_W-1:0]   result_offset,
	output logic [1:0]                   status,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ffha_pkg::PA_W-1:0]    paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	localparam int AW = $clog2(HEAP_BYTES + 1);
	localparam int NW = $clog2(2 ** ffha_pkg::REQ_W + HEADER_BYTES);
	localparam int CW = NW + 1;
	localparam int N  = MAX_BLOCKS;

	ffha_pkg::fsm_t              state_q, state_d;
	ffha_pkg::bc_t               bc_q;
	logic [NW-1:0]               need_q;
	logic [AW-1:0]               heap_top_q;
	logic [ffha_pkg::GRW_W-1:0]  mgs_q;
	logic [ffha_pkg::GRW_W-1:0]  gran;
	logic                        out_valid_q;
	logic [ffha_pkg::RES_W-1:0]  res_q, out_res_q;
	ffha_pkg::status_t           st_q, out_st_q;

	logic                        accept, launch, capture, load_out;
	logic                        calc_done;
	logic [CW-1:0]               calc;

	logic                        v_p   [0:N+2];
	logic                        tok_p [0:N+2];
	logic [AW-1:0]               size_p[0:N+2];
	logic [AW-1:0]               cap_p [0:N+2];
	ffha_pkg::tok_t              tin_a [0:N-1];
	ffha_pkg::tok_t              tout_a[0:N-1];
	logic [AW-1:0]               toff_a[0:N-1];
	logic [AW-1:0]               tinoff_a[0:N-1];
	ffha_pkg::act_t              actr_a[0:N-1];
	ffha_pkg::act_t              act_all;
	logic [N-1:0]                v_vec, tok_vec;
	ffha_pkg::tok_t              first_tok;
	ffha_pkg::tok_t              exit_tok;

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == ffha_pkg::REG_MIN_GROW) ? 32'(mgs_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mgs_q <= ffha_pkg::MIN_GROW_RST;
		else if (psel && penable && pwrite && paddr[2] == ffha_pkg::REG_MIN_GROW)
			mgs_q <= pwdata[ffha_pkg::GRW_W-1:0];
	end

	assign gran = (mgs_q < ffha_pkg::GRW_W'(2 * HEADER_BYTES)) ?
		ffha_pkg::GRW_W'(2 * HEADER_BYTES) : mgs_q;

	// sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			ffha_pkg::S_IDLE: if (in_valid) state_d = ffha_pkg::S_CALC;
			ffha_pkg::S_CALC: if (calc_done) state_d = ffha_pkg::S_WALK;
			ffha_pkg::S_WALK: if (exit_tok.tok) state_d = ffha_pkg::S_HOLD;
			ffha_pkg::S_HOLD: if (!out_valid_q || !out_stall) state_d = ffha_pkg::S_IDLE;
			default:          state_d = ffha_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_stall = (state_q != ffha_pkg::S_IDLE);
		accept   = in_valid && (state_q == ffha_pkg::S_IDLE);
		launch   = (state_q == ffha_pkg::S_CALC) && calc_done;
		capture  = (state_q == ffha_pkg::S_WALK) && exit_tok.tok;
		load_out = (state_q == ffha_pkg::S_HOLD) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ffha_pkg::S_IDLE;
			heap_top_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (act_all.grow)
				heap_top_q <= AW'(CW'(heap_top_q) + calc);
			if (load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bc_q.cmd <= command;
			bc_q.req <= request_size;
			bc_q.dat <= data_offset;
			need_q   <= NW'(request_size) + NW'(HEADER_BYTES);
		end
		if (capture) begin
			res_q <= exit_tok.res;
			// undecided at the exit: every cell held a record and none matched
			if (exit_tok.done)
				st_q <= exit_tok.st;
			else if (bc_q.cmd == ffha_pkg::CMD_FREE)
				st_q <= ffha_pkg::ST_BADFREE;
			else
				st_q <= ffha_pkg::ST_FULL;
		end
		if (load_out) begin
			out_res_q <= (st_q == ffha_pkg::ST_OK) ? res_q : '0;
			out_st_q  <= st_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign result_offset = out_res_q;
	assign status        = out_st_q;

	ffha_grow #(
		.NW(NW),
		.CW(CW)
	) u_grow (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.need   (NW'(request_size) + NW'(HEADER_BYTES)),
		.gran   (gran),
		.done   (calc_done),
		.calc   (calc)
	);

	// token entering the bottom cell
	always_comb begin
		first_tok     = '0;
		first_tok.tok = launch;
		if (bc_q.cmd == ffha_pkg::CMD_ALLOC && bc_q.req == '0) begin
			first_tok.done = 1'b1;
			first_tok.st   = ffha_pkg::ST_ZERO;
		end
	end

	assign v_p[0]      = 1'b0;
	assign tok_p[0]    = 1'b0;
	assign size_p[0]   = '0;
	assign cap_p[0]    = '0;
	assign v_p[N+1]    = 1'b0;
	assign tok_p[N+1]  = 1'b0;
	assign size_p[N+1] = '0;
	assign cap_p[N+1]  = '0;
	assign v_p[N+2]    = 1'b0;
	assign tok_p[N+2]  = 1'b0;
	assign size_p[N+2] = '0;
	assign cap_p[N+2]  = '0;

	genvar gi;
	generate
		for (gi = 0; gi < N; gi++) begin : g_cell
			if (gi == 0) begin : g_first
				assign tin_a[gi]    = first_tok;
				assign tinoff_a[gi] = '0;
			end else begin : g_rest
				assign tin_a[gi]    = tout_a[gi-1];
				assign tinoff_a[gi] = toff_a[gi-1];
			end

			ffha_cell #(
				.HEAP (HEAP_BYTES),
				.HDR  (HEADER_BYTES),
				.AW   (AW),
				.NW   (NW),
				.CW   (CW)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.bc         (bc_q),
				.need       (need_q),
				.calc       (calc),
				.heap_top   (heap_top_q),
				.table_full (v_p[N]),
				.launch     (launch),
				.act        (act_all),
				.dn_v       (v_p[gi]),
				.dn_size    (size_p[gi]),
				.dn_cap     (cap_p[gi]),
				.dn_tok     (tok_p[gi]),
				.up1_v      (v_p[gi+2]),
				.up1_size   (size_p[gi+2]),
				.up1_cap    (cap_p[gi+2]),
				.up1_tok    (tok_p[gi+2]),
				.up2_v      (v_p[gi+3]),
				.up2_size   (size_p[gi+3]),
				.up2_cap    (cap_p[gi+3]),
				.tin        (tin_a[gi]),
				.tin_off    (tinoff_a[gi]),
				.v          (v_p[gi+1]),
				.size       (size_p[gi+1]),
				.cap        (cap_p[gi+1]),
				.tok        (tok_p[gi+1]),
				.tout       (tout_a[gi]),
				.tout_off   (toff_a[gi]),
				.act_req    (actr_a[gi])
			);

			assign v_vec[gi]   = v_p[gi+1];
			assign tok_vec[gi] = tok_p[gi+1];
		end
	endgenerate

	assign exit_tok = tout_a[N-1];

	always_comb begin
		act_all = '0;
		for (int i = 0; i < N; i++)
			act_all = act_all | actr_a[i];
	end

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_vec))
		else $error("more than one token in the chain");

	a_act_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(act_all != '0) |-> (state_q == ffha_pkg::S_WALK))
		else $error("chain edit outside a walk");

	a_packed: assert property (@(posedge clk) disable iff (!arst_n)
		((v_vec + N'(1)) & v_vec) == '0)
		else $error("valid cells not packed at the bottom");

	a_heap_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(heap_top_q) <= 32'(HEAP_BYTES))
		else $error("heap top past heap size");

	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ffha_pkg::S_HOLD && !out_valid_q) |=> out_valid_q)
		else $error("result not moved to the output register");

endmodule
